[src/ffsa_pkg.sv]
// Shared types and constants for the first-fit segment allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int DATA_W           = 32;
  localparam int POS_W            = DATA_W + 1;
  localparam int ADDR_BITS        = 32;
  localparam int DESCRIPTOR_BYTES = 16;
  localparam int HDR_SHIFT        = 11;
  localparam int REGIONS_DEF      = 8;
  localparam int SEGMENTS_DEF     = 64;
  localparam logic [63:0] AMAX = (ADDR_BITS >= 64) ? '1 :
                                 ((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_e_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NO_REGION = 3'd3,
    ST_NO_DESC   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] length;
    logic [DATA_W-1:0] alignment;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] result_address;
  } out_item_t;

endpackage

[src/ffsa_region_cell.sv]
// One region slot: presence, base address and list head.
// Cells chain a carry so that the lowest empty slot claims the next add. Uses ffsa_pkg.
`timescale 1ns / 1ps
module ffsa_region_cell #(
  parameter int LinkW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          chain_in,
  output logic                          chain_out,
  output logic                          claim,
  input  logic                          wr_en,
  input  logic [ffsa_pkg::DATA_W-1:0]   wr_start,
  input  logic [LinkW-1:0]              wr_first,
  output logic                          present,
  output logic [ffsa_pkg::DATA_W-1:0]   start,
  output logic [LinkW-1:0]              first
);
  import ffsa_pkg::*;

  logic              present_r;
  logic [DATA_W-1:0] start_r;
  logic [LinkW-1:0]  first_r;

  assign claim     = chain_in & ~present_r;
  assign chain_out = chain_in & present_r;
  assign present   = present_r;
  assign start     = start_r;
  assign first     = first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
    end else if (wr_en && claim) begin
      present_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && claim) begin
      start_r <= wr_start;
      first_r <= wr_first;
    end
  end

endmodule

[src/ffsa_rem.sv]
// Bit-serial remainder unit, one dividend bit per cycle.
// Divisor must be non-zero. Uses ffsa_pkg.
`timescale 1ns / 1ps
module ffsa_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ffsa_pkg::POS_W-1:0]   dividend,
  input  logic [ffsa_pkg::DATA_W-1:0]  divisor,
  output logic                         done,
  output logic [ffsa_pkg::DATA_W-1:0]  rem
);
  import ffsa_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W:0]   trial;

  assign done = done_r;
  assign rem  = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[POS_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(POS_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DATA_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DATA_W-1:0];
      end
      dvd_nxt = {dvd_r[POS_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

endmodule

[src/first_fit_segment_allocator.sv]
// First-fit segment allocator top level: sequencer, segment and free-index memories.
// Depends on ffsa_pkg, ffsa_region_cell and ffsa_rem.
//
//   channel | direction | payload
//   in_     | input     | ffsa_pkg::in_item_t  (action, address, length, alignment)
//   out_    | output    | ffsa_pkg::out_item_t (status, result_address)
//
// One item at a time; the sequencer scans the region slots, walks the segments of each
// list, tests each free segment that is large enough for a fit (an aligned fit waits
// for the serial remainder unit) and then updates the lists.
// After reset the free-index memory is filled with in_stall high.
// The result sits in an output register; the next item is taken while it waits.
`timescale 1ns / 1ps
module first_fit_segment_allocator #(
  parameter int REGIONS  = ffsa_pkg::REGIONS_DEF,
  parameter int SEGMENTS = ffsa_pkg::SEGMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffsa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffsa_pkg::out_item_t  out_data
);
  import ffsa_pkg::*;

  localparam int LW  = $clog2(SEGMENTS + 1);
  localparam int IW  = $clog2(SEGMENTS);
  localparam int CW  = LW;
  localparam int RCW = $clog2(REGIONS + 1);
  localparam int RIW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int SW  = 1 + DATA_W + LW;
  localparam logic [LW-1:0] END_LINK = LW'(SEGMENTS);

  typedef enum logic [19:0] {
    S_CLR      = 20'h00001,
    S_IDLE     = 20'h00002,
    S_START    = 20'h00004,
    S_ADD_CHK  = 20'h00008,
    S_ADD_POPF = 20'h00010,
    S_ADD_WF   = 20'h00020,
    S_ADD_POPH = 20'h00040,
    S_ADD_WH   = 20'h00080,
    S_REG      = 20'h00100,
    S_CHK      = 20'h00200,
    S_DIV      = 20'h00400,
    S_FIT      = 20'h00800,
    S_APOPC    = 20'h01000,
    S_AWS      = 20'h02000,
    S_APOPD    = 20'h04000,
    S_AWD      = 20'h08000,
    S_AWCUR    = 20'h10000,
    S_FNX      = 20'h20000,
    S_FMRG     = 20'h40000,
    S_OUT      = 20'h80000
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [DATA_W-1:0] addr_r, addr_nxt, len_r, len_nxt, align_r, align_nxt;
  logic [DATA_W-1:0] hdr_r, hdr_nxt;
  logic [RCW-1:0]    r_r, r_nxt;
  logic [LW-1:0]     s_r, s_nxt, prev_r, prev_nxt;
  logic [POS_W-1:0]  p_r, p_nxt, top_r, top_nxt, at_r, at_nxt;
  logic              cur_used_r, cur_used_nxt, prev_used_r, prev_used_nxt;
  logic [DATA_W-1:0] cur_len_r, cur_len_nxt, prev_len_r, prev_len_nxt;
  logic [LW-1:0]     cur_link_r, cur_link_nxt;
  logic [DATA_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic [LW-1:0]     c_r, c_nxt, d_r, d_nxt;
  logic [DATA_W-1:0] mlen_r, mlen_nxt;
  logic [LW-1:0]     mlink_r, mlink_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  status_e_t         st_r, st_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // memories
  logic [SW-1:0] seg_mem [SEGMENTS];
  logic [SW-1:0] seg_rd, seg_wd;
  logic [IW-1:0] seg_ra, seg_wa;
  logic          seg_we;
  logic [IW-1:0] fl_mem [SEGMENTS];
  logic [IW-1:0] fl_rd, fl_wd, fl_ra, fl_wa;
  logic          fl_we;

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    seg_rd <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_wa] <= fl_wd;
    end
    fl_rd <= fl_mem[fl_ra];
  end

  // region cells
  logic [REGIONS:0]  rg_chain;
  logic [REGIONS-1:0] rg_claim, rg_present;
  logic [DATA_W-1:0] rg_start [REGIONS];
  logic [LW-1:0]     rg_first [REGIONS];
  logic              rg_we;
  logic [LW-1:0]     rg_wfirst;

  assign rg_chain[0] = 1'b1;

  for (genvar g = 0; g < REGIONS; g++) begin : g_region
    ffsa_region_cell #(.LinkW(LW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .chain_in  (rg_chain[g]),
      .chain_out (rg_chain[g+1]),
      .claim     (rg_claim[g]),
      .wr_en     (rg_we),
      .wr_start  (addr_r),
      .wr_first  (rg_wfirst),
      .present   (rg_present[g]),
      .start     (rg_start[g]),
      .first     (rg_first[g])
    );
  end

  // remainder unit
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_rem;

  ffsa_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (top_nxt),
    .divisor  (align_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  logic              rd_used;
  logic [DATA_W-1:0] rd_len;
  logic [LW-1:0]     rd_link;
  logic              adv, adv_used;
  logic [DATA_W-1:0] adv_len;
  logic [LW-1:0]     adv_link;
  logic [DATA_W:0]   add_end;
  logic [POS_W-1:0]  top_c;
  logic [DATA_W-1:0] left_c, right_c;
  logic [1:0]        need;
  logic [RIW-1:0]    ri;
  logic [LW-1:0]     cur_idx, cur_lnk;

  assign rd_used  = seg_rd[SW-1];
  assign rd_len   = seg_rd[SW-2 -: DATA_W];
  assign rd_link  = seg_rd[LW-1:0];
  assign ri       = RIW'(r_r);
  assign add_end  = {1'b0, addr_r} + {1'b0, len_r} - {{DATA_W{1'b0}}, 1'b1};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    align_nxt     = align_r;
    hdr_nxt       = hdr_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    prev_nxt      = prev_r;
    p_nxt         = p_r;
    top_nxt       = top_r;
    at_nxt        = at_r;
    cur_used_nxt  = cur_used_r;
    cur_len_nxt   = cur_len_r;
    cur_link_nxt  = cur_link_r;
    prev_used_nxt = prev_used_r;
    prev_len_nxt  = prev_len_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    mlen_nxt      = mlen_r;
    mlink_nxt     = mlink_r;
    cnt_nxt       = cnt_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    seg_we        = 1'b0;
    seg_wa        = '0;
    seg_wd        = '0;
    seg_ra        = IW'(s_r);
    fl_we         = 1'b0;
    fl_wa         = IW'(cnt_r);
    fl_wd         = '0;
    fl_ra         = IW'(cnt_r - 1'b1);
    div_start     = 1'b0;
    rg_we         = 1'b0;
    rg_wfirst     = '0;
    adv           = 1'b0;
    adv_used      = cur_used_r;
    adv_len       = cur_len_r;
    adv_link      = cur_link_r;
    top_c         = '0;
    left_c        = '0;
    right_c       = '0;
    need          = '0;
    cur_idx       = '0;
    cur_lnk       = '0;

    case (state_r)
      S_CLR: begin
        fl_we   = 1'b1;
        fl_wd   = IW'(cnt_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SEGMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_data.action;
          addr_nxt  = in_data.address;
          len_nxt   = in_data.length;
          align_nxt = in_data.alignment;
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_nxt = '0;
        case (act_r)
          ACT_ADD: begin
            if (len_r == '0) begin
              st_nxt = ST_ZERO; state_nxt = S_OUT;
            end else if (rg_claim == '0) begin
              st_nxt = ST_NO_REGION; state_nxt = S_OUT;
            end else begin
              hdr_nxt   = DATA_W'((DATA_W'(len_r >> HDR_SHIFT) + 1'b1) * DESCRIPTOR_BYTES);
              state_nxt = S_ADD_CHK;
            end
          end
          ACT_ALLOC: begin
            if (len_r == '0) begin
              st_nxt = ST_ZERO; state_nxt = S_OUT;
            end else begin
              r_nxt = '0; state_nxt = S_REG;
            end
          end
          ACT_FREE: begin
            r_nxt = '0; state_nxt = S_REG;
          end
          default: begin
            st_nxt = ST_NOT_FOUND; state_nxt = S_OUT;
          end
        endcase
      end
      S_ADD_CHK: begin
        if (hdr_r > len_r || {{(63-DATA_W){1'b0}}, add_end} > AMAX) begin
          st_nxt = ST_NO_FIT; state_nxt = S_OUT;
        end else if (cnt_r < ((hdr_r < len_r) ? CW'(2) : CW'(1))) begin
          st_nxt = ST_NO_DESC; state_nxt = S_OUT;
        end else if (hdr_r < len_r) begin
          state_nxt = S_ADD_POPF;
        end else begin
          state_nxt = S_ADD_POPH;
        end
      end
      S_ADD_POPF: begin
        cnt_nxt = cnt_r - 1'b1; state_nxt = S_ADD_WF;
      end
      S_ADD_WF: begin
        c_nxt  = LW'(fl_rd);
        seg_we = 1'b1;
        seg_wa = fl_rd;
        seg_wd = {1'b0, len_r - hdr_r, END_LINK};
        state_nxt = S_ADD_POPH;
      end
      S_ADD_POPH: begin
        cnt_nxt = cnt_r - 1'b1; state_nxt = S_ADD_WH;
      end
      S_ADD_WH: begin
        seg_we    = 1'b1;
        seg_wa    = fl_rd;
        seg_wd    = {1'b1, hdr_r, (hdr_r < len_r) ? c_r : END_LINK};
        rg_we     = 1'b1;
        rg_wfirst = LW'(fl_rd);
        st_nxt    = ST_OK;
        state_nxt = S_OUT;
      end
      S_REG: begin
        if (r_r == RCW'(REGIONS)) begin
          st_nxt    = (act_r == ACT_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else if (!rg_present[ri]) begin
          r_nxt = r_r + 1'b1;
        end else begin
          p_nxt     = POS_W'(rg_start[ri]);
          s_nxt     = rg_first[ri];
          prev_nxt  = END_LINK;
          seg_ra    = IW'(rg_first[ri]);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cur_used_nxt = rd_used;
        cur_len_nxt  = rd_len;
        cur_link_nxt = rd_link;
        adv_used     = rd_used;
        adv_len      = rd_len;
        adv_link     = rd_link;
        if (act_r == ACT_ALLOC) begin
          if (!rd_used && rd_len >= len_r) begin
            top_c   = p_r + POS_W'(rd_len) - POS_W'(len_r);
            top_nxt = top_c;
            if (align_r != '0) begin
              div_start = 1'b1; state_nxt = S_DIV;
            end else begin
              at_nxt = top_c; state_nxt = S_FIT;
            end
          end else begin
            adv = 1'b1;
          end
        end else begin
          if (POS_W'(addr_r) >= p_r && (POS_W'(addr_r) - p_r) < POS_W'(rd_len)) begin
            if (!rd_used || prev_r == END_LINK) begin
              st_nxt = ST_NOT_FOUND; state_nxt = S_OUT;
            end else if (rd_link != END_LINK) begin
              seg_ra = IW'(rd_link); state_nxt = S_FNX;
            end else begin
              mlen_nxt = rd_len; mlink_nxt = rd_link; state_nxt = S_FMRG;
            end
          end else begin
            adv = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          at_nxt = top_r - POS_W'(div_rem); state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        if (at_r >= p_r) begin
          left_c  = DATA_W'(at_r - p_r);
          right_c = cur_len_r - left_c - len_r;
          need    = {1'b0, left_c != '0} + {1'b0, right_c != '0};
          left_nxt  = left_c;
          right_nxt = right_c;
          if (cnt_r < CW'(need)) begin
            st_nxt = ST_NO_DESC; state_nxt = S_OUT;
          end else if (left_c != '0) begin
            state_nxt = S_APOPC;
          end else if (right_c != '0) begin
            state_nxt = S_APOPD;
          end else begin
            state_nxt = S_AWCUR;
          end
        end else begin
          adv = 1'b1;
        end
      end
      S_APOPC: begin
        cnt_nxt = cnt_r - 1'b1; state_nxt = S_AWS;
      end
      S_AWS: begin
        c_nxt  = LW'(fl_rd);
        seg_we = 1'b1;
        seg_wa = IW'(s_r);
        seg_wd = {1'b0, left_r, LW'(fl_rd)};
        state_nxt = (right_r != '0) ? S_APOPD : S_AWCUR;
      end
      S_APOPD: begin
        cnt_nxt = cnt_r - 1'b1; state_nxt = S_AWD;
      end
      S_AWD: begin
        d_nxt  = LW'(fl_rd);
        seg_we = 1'b1;
        seg_wa = fl_rd;
        seg_wd = {1'b0, right_r, cur_link_r};
        state_nxt = S_AWCUR;
      end
      S_AWCUR: begin
        cur_idx   = (left_r != '0) ? c_r : s_r;
        cur_lnk   = (right_r != '0) ? d_r : cur_link_r;
        seg_we    = 1'b1;
        seg_wa    = IW'(cur_idx);
        seg_wd    = {1'b1, len_r, cur_lnk};
        st_nxt    = ST_OK;
        res_nxt   = at_r[DATA_W-1:0];
        state_nxt = S_OUT;
      end
      S_FNX: begin
        if (!rd_used) begin
          mlen_nxt  = cur_len_r + rd_len;
          mlink_nxt = rd_link;
          fl_we     = 1'b1;
          fl_wd     = IW'(cur_link_r);
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          mlen_nxt  = cur_len_r;
          mlink_nxt = cur_link_r;
        end
        state_nxt = S_FMRG;
      end
      S_FMRG: begin
        seg_we = 1'b1;
        if (!prev_used_r) begin
          seg_wa  = IW'(prev_r);
          seg_wd  = {1'b0, prev_len_r + mlen_r, mlink_r};
          fl_we   = 1'b1;
          fl_wd   = IW'(s_r);
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          seg_wa = IW'(s_r);
          seg_wd = {1'b0, mlen_r, mlink_r};
        end
        st_nxt    = ST_OK;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = st_r;
          out_nxt.result_address = res_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next segment of the list
    if (adv) begin
      p_nxt         = p_r + POS_W'(adv_len);
      prev_nxt      = s_r;
      prev_used_nxt = adv_used;
      prev_len_nxt  = adv_len;
      s_nxt         = adv_link;
      seg_ra        = IW'(adv_link);
      if (adv_link == END_LINK) begin
        r_nxt     = r_r + 1'b1;
        state_nxt = S_REG;
      end else begin
        state_nxt = S_CHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    addr_r      <= addr_nxt;
    len_r       <= len_nxt;
    align_r     <= align_nxt;
    hdr_r       <= hdr_nxt;
    r_r         <= r_nxt;
    s_r         <= s_nxt;
    prev_r      <= prev_nxt;
    p_r         <= p_nxt;
    top_r       <= top_nxt;
    at_r        <= at_nxt;
    cur_used_r  <= cur_used_nxt;
    cur_len_r   <= cur_len_nxt;
    cur_link_r  <= cur_link_nxt;
    prev_used_r <= prev_used_nxt;
    prev_len_r  <= prev_len_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    c_r         <= c_nxt;
    d_r         <= d_nxt;
    mlen_r      <= mlen_nxt;
    mlink_r     <= mlink_nxt;
    st_r        <= st_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

endmodule

[test/testbench.sv]
// Testbench for first_fit_segment_allocator: directed table then random traffic.
// Checks each result against the table's expected value or a built-in allocator predictor; depends on ffsa_pkg.
`timescale 1ns / 1ps
module testbench;
  import ffsa_pkg::*;

  localparam int NREG = 8;
  localparam int NSEG = 64;
  localparam longint unsigned ADDR_MAX = 64'hFFFF_FFFF;

  typedef struct {
    action_e_t   action;
    logic [31:0] address;
    logic [31:0] length;
    logic [31:0] alignment;
    bit          typed;
    status_e_t   exp_status;
    logic [31:0] exp_addr;
    bit          free_last;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  first_fit_segment_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // allocator mirror
  bit              rg_present [NREG];
  longint unsigned rg_start   [NREG];
  longint unsigned rg_len     [NREG];
  int              rg_first   [NREG];
  bit              sg_present [NSEG];
  bit              sg_used    [NSEG];
  longint unsigned sg_len     [NSEG];
  int              sg_link    [NSEG];

  out_item_t   expected_results[$];
  logic [31:0] live_blocks[$];
  logic [31:0] last_block;
  int          fails;
  int          results_seen;
  stim_row_t   directed[$];

  function automatic int free_descriptors();
    int n;
    n = 0;
    for (int i = 0; i < NSEG; i++) if (!sg_present[i]) n++;
    return n;
  endfunction

  function automatic int take_descriptor(bit used, longint unsigned len, int link);
    for (int i = 0; i < NSEG; i++) begin
      if (!sg_present[i]) begin
        sg_present[i] = 1'b1;
        sg_used[i]    = used;
        sg_len[i]     = len;
        sg_link[i]    = link;
        return i;
      end
    end
    return NSEG;
  endfunction

  function automatic status_e_t add_region(longint unsigned base, longint unsigned len);
    int r, h, f;
    longint unsigned hdr;
    if (len == 0) return ST_ZERO;
    r = 0;
    while (r < NREG && rg_present[r]) r++;
    if (r >= NREG) return ST_NO_REGION;
    hdr = (len / 2048 + 1) * DESCRIPTOR_BYTES;
    if (hdr > len || base + len - 1 > ADDR_MAX) return ST_NO_FIT;
    if (free_descriptors() < ((hdr < len) ? 2 : 1)) return ST_NO_DESC;
    f = NSEG;
    if (hdr < len) f = take_descriptor(1'b0, len - hdr, NSEG);
    h = take_descriptor(1'b1, hdr, f);
    rg_present[r] = 1'b1;
    rg_start[r]   = base;
    rg_len[r]     = len;
    rg_first[r]   = h;
    return ST_OK;
  endfunction

  function automatic status_e_t allocate(longint unsigned size, longint unsigned align,
                                         output longint unsigned at);
    int s, cur, need;
    longint unsigned p, l, left, right, top;
    at = 0;
    if (size == 0) return ST_ZERO;
    for (int r = 0; r < NREG; r++) begin
      if (!rg_present[r]) continue;
      p = rg_start[r];
      s = rg_first[r];
      for (int n = 0; s < NSEG && sg_present[s] && n < NSEG; n++) begin
        l = sg_len[s];
        if (!sg_used[s] && l >= size) begin
          top = p + l - size;
          at  = (align != 0) ? top - top % align : top;
          if (at >= p) begin
            left  = at - p;
            right = l - left - size;
            need  = (left != 0) + (right != 0);
            if (free_descriptors() < need) return ST_NO_DESC;
            cur = s;
            if (left != 0) begin
              cur        = take_descriptor(1'b1, l - left, sg_link[s]);
              sg_len[s]  = left;
              sg_link[s] = cur;
            end
            sg_used[cur] = 1'b1;
            if (right != 0) sg_link[cur] = take_descriptor(1'b0, right, sg_link[cur]);
            sg_len[cur] = size;
            return ST_OK;
          end
        end
        p += l;
        s = sg_link[s];
      end
    end
    return ST_NO_FIT;
  endfunction

  function automatic status_e_t free_block(longint unsigned addr);
    int s, prev, nx;
    longint unsigned p, l;
    for (int r = 0; r < NREG; r++) begin
      if (!rg_present[r]) continue;
      p    = rg_start[r];
      s    = rg_first[r];
      prev = NSEG;
      for (int n = 0; s < NSEG && sg_present[s] && n < NSEG; n++) begin
        l = sg_len[s];
        if (addr >= p && addr - p < l) begin
          if (!sg_used[s] || prev == NSEG) return ST_NOT_FOUND;
          sg_used[s] = 1'b0;
          nx = sg_link[s];
          if (nx < NSEG && sg_present[nx] && !sg_used[nx]) begin
            sg_len[s]      += sg_len[nx];
            sg_link[s]      = sg_link[nx];
            sg_present[nx]  = 1'b0;
          end
          if (!sg_used[prev]) begin
            sg_len[prev]  += sg_len[s];
            sg_link[prev]  = sg_link[s];
            sg_present[s]  = 1'b0;
          end
          return ST_OK;
        end
        p += l;
        prev = s;
        s = sg_link[s];
      end
    end
    return ST_NOT_FOUND;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t o;
    status_e_t st;
    longint unsigned at;
    at = 0;
    case (it.action)
      ACT_ADD:   st = add_region(it.address, it.length);
      ACT_ALLOC: st = allocate(it.length, it.alignment, at);
      ACT_FREE:  st = free_block(it.address);
      default:   st = ST_NOT_FOUND;
    endcase
    if (st != ST_OK) at = 0;
    if (it.action == ACT_ALLOC && st == ST_OK) begin
      last_block = at[31:0];
      live_blocks.push_back(at[31:0]);
    end
    o.status         = st;
    o.result_address = at[31:0];
    return o;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_exp);
    out_item_t p;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    p = predict_result(it);
    expected_results.push_back(typed ? typed_exp : p);
  endtask

  task automatic maybe_gap(int burst_left);
    int gap;
    if (burst_left > 0) return;
    gap = $urandom_range(0, 12);
    if (gap == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  function automatic void add_row(action_e_t a, logic [31:0] ad, logic [31:0] ln,
                                  logic [31:0] al, bit typed, status_e_t st, bit fl);
    stim_row_t r;
    r.action = a; r.address = ad; r.length = ln; r.alignment = al;
    r.typed = typed; r.exp_status = st; r.exp_addr = '0; r.free_last = fl;
    directed.push_back(r);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int k;
    it.address   = $urandom;
    it.length    = $urandom;
    it.alignment = $urandom;
    k = $urandom_range(0, 99);
    if (k < 48) begin
      it.action = ACT_ALLOC;
      if ($urandom_range(0, 9) != 0) it.length = $urandom_range(1, 3000);
      case ($urandom_range(0, 3))
        0: it.alignment = '0;
        1, 2: it.alignment = 32'd1 << $urandom_range(0, 15);
        default: ;
      endcase
    end else if (k < 90) begin
      it.action = ACT_FREE;
      if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        it.address = live_blocks[k] + $urandom_range(0, 3);
        live_blocks.delete(k);
      end
    end else if (k < 96) begin
      it.action = ACT_ADD;
      if ($urandom_range(0, 1)) it.length = $urandom_range(0, 4096);
    end else begin
      it.action = action_e_t'(2'd3);
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: status %0d address %h",
               out_data.status, out_data.result_address);
        fails++;
      end else begin
        if (out_data.status !== expected_results[0].status) begin
          $error("status: expected %0d, got %0d",
                 expected_results[0].status, out_data.status);
          fails++;
        end
        if (out_data.result_address !== expected_results[0].result_address) begin
          $error("result_address: expected %h, got %h",
                 expected_results[0].result_address, out_data.result_address);
          fails++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    int span;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  initial begin
    #100000000;
    $display("first_fit_segment_allocator test failed");
    $finish;
  end

  initial begin
    in_item_t  it;
    out_item_t te;
    int burst;
    for (int i = 0; i < NREG; i++) rg_present[i] = 1'b0;
    for (int i = 0; i < NSEG; i++) sg_present[i] = 1'b0;
    fails = 0;
    results_seen = 0;
    last_block = '0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(ACT_FREE,  32'h0,          32'h0,          32'h0,        1, ST_NOT_FOUND, 0);
    add_row(ACT_ALLOC, 32'h0,          32'h10,         32'h0,        1, ST_NO_FIT,    0);
    add_row(ACT_ALLOC, 32'h0,          32'h0,          32'h0,        1, ST_ZERO,      0);
    add_row(ACT_ADD,   32'h8000,       32'h0,          32'h0,        1, ST_ZERO,      0);
    add_row(action_e_t'(2'd3), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1, ST_NOT_FOUND, 0);
    add_row(ACT_ADD,   32'hFFFF_F000,  32'h2000,       32'h0,        1, ST_NO_FIT,    0);
    add_row(ACT_ADD,   32'h2000,       32'h8,          32'h0,        1, ST_NO_FIT,    0);
    add_row(ACT_ADD,   32'h1000,       32'h10,         32'h0,        1, ST_OK,        0);
    add_row(ACT_ADD,   32'h10000,      32'h10000,      32'h0,        1, ST_OK,        0);
    add_row(ACT_ALLOC, 32'h0,          32'h100,        32'h0,        0, ST_OK,        0);
    add_row(ACT_ALLOC, 32'h0,          32'h100,        32'h1000,     0, ST_OK,        0);
    add_row(ACT_ALLOC, 32'h0,          32'hFFFF_FFFF,  32'h0,        1, ST_NO_FIT,    0);
    add_row(ACT_ALLOC, 32'h0,          32'h1,          32'hFFFF_FFFF, 0, ST_OK,       0);
    add_row(ACT_FREE,  32'h10000,      32'h0,          32'h0,        1, ST_NOT_FOUND, 0);
    add_row(ACT_FREE,  32'h0,          32'h0,          32'h0,        0, ST_OK,        1);
    add_row(ACT_ADD,   32'hFFFF_0000,  32'h10000,      32'h0,        1, ST_OK,        0);
    add_row(ACT_ALLOC, 32'h0,          32'h40,         32'h1,        0, ST_OK,        0);
    add_row(ACT_ADD,   32'h0010_0000,  32'h10_0000,    32'h0,        1, ST_OK,        0);
    add_row(ACT_ADD,   32'h0040_0000,  32'h10_0000,    32'h0,        1, ST_OK,        0);
    add_row(ACT_ADD,   32'h0100_0000,  32'h10_0000,    32'h0,        1, ST_OK,        0);
    add_row(ACT_ADD,   32'h0200_0000,  32'h10_0000,    32'h0,        1, ST_OK,        0);
    add_row(ACT_ADD,   32'h0400_0000,  32'h10_0000,    32'h0,        1, ST_OK,        0);
    add_row(ACT_ADD,   32'h0800_0000,  32'h10_0000,    32'h0,        1, ST_NO_REGION, 0);
    add_row(ACT_FREE,  32'h0,          32'h0,          32'h0,        0, ST_OK,        1);

    foreach (directed[i]) begin
      it.action    = directed[i].action;
      it.address   = directed[i].free_last ? last_block : directed[i].address;
      it.length    = directed[i].length;
      it.alignment = directed[i].alignment;
      te.status         = directed[i].exp_status;
      te.result_address = directed[i].exp_addr;
      send_item(it, directed[i].typed, te);
    end

    burst = 0;
    for (int n = 0; n < 1250; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        maybe_gap(0);
      end
      burst--;
      it = random_item();
      te = '0;
      send_item(it, 1'b0, te);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("first_fit_segment_allocator test passed");
    end else begin
      $display("first_fit_segment_allocator test failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/ffsa_pkg.sv
src/ffsa_region_cell.sv
src/ffsa_rem.sv
src/first_fit_segment_allocator.sv
test/testbench.sv
